>>> rtl/tlsgw_pkg.sv
// Package with constants, stage types and per-stage step functions of the TLS weight pipeline.
`default_nettype none

package tlsgw_pkg;

	// Fixed-point constants.
	localparam logic [16:0] MU_ONE   = 17'd65536;
	localparam logic [47:0] LOSS_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] SHAPE_RESET = 32'd65536;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SHAPE  = 2'd0;
	localparam logic [1:0] CFG_MU     = 2'd1;
	localparam logic [1:0] CFG_SCHEME = 2'd2;

	// Graduation schemes; the unused code behaves as standard.
	localparam logic [1:0] SCH_STD = 2'd0;
	localparam logic [1:0] SCH_LIN = 2'd1;
	localparam logic [1:0] SCH_SUP = 2'd2;

	// Stage counts of the iterative units.
	localparam int unsigned NF_DIV  = 64;
	localparam int unsigned NF_SQ   = 32;
	localparam int unsigned NB_DIV  = 17;
	localparam int unsigned NR_SQ   = 56;
	localparam int unsigned NR_DIV  = 57;
	localparam int unsigned NS_DIV  = 48;
	localparam int unsigned N_SIDE  = 116;
	localparam int unsigned N_VALID = 121;

	// Per-item flags that ride alongside the long units.
	typedef struct packed {
		logic        beyond;
		logic        le_p;
		logic        lin_zero;
		logic        std_one;
		logic        sup_zero;
		logic [45:0] half_d2;
	} side_t;

	// Fractional quotient num/d2 with 64 fraction bits.
	typedef struct packed {
		logic [62:0] rem;
		logic [63:0] q;
		logic [62:0] den;
	} fdiv_t;

	// Square root of the 64-bit quotient.
	typedef struct packed {
		logic [32:0] rem;
		logic [31:0] root;
		logic [63:0] xs;
	} fsq_t;

	// Blend division by (1 - mu), 17 quotient bits.
	typedef struct packed {
		logic        zero;
		logic        ovf;
		logic [16:0] rem;
		logic [16:0] nq;
	} fbl_t;

	// Partial products of p * d2.
	typedef struct packed {
		logic [63:0] pp0;
		logic [48:0] pp1;
		logic [62:0] pp2;
		logic [47:0] pp3;
		logic [49:0] t;
	} rmul_t;

	// Square root of p * d2.
	typedef struct packed {
		logic [56:0]  rem;
		logic [55:0]  root;
		logic [111:0] xs;
		logic [49:0]  t;
	} rsq_t;

	// Linear loss division by 2 * (1 - mu).
	typedef struct packed {
		logic [17:0] rem;
		logic [56:0] nq;
	} rdiv_t;

	// Standard loss division by mu.
	typedef struct packed {
		logic [16:0] rem;
		logic [47:0] nq;
	} sdiv_t;

	// One quotient bit of the fractional division.
	function automatic fdiv_t fdiv_step(fdiv_t x);
		logic [63:0] rs;
		fdiv_t y;
		rs = {x.rem, 1'b0};
		y = x;
		if (rs >= {1'b0, x.den}) begin
			y.rem = 63'(rs - {1'b0, x.den});
			y.q   = {x.q[62:0], 1'b1};
		end else begin
			y.rem = rs[62:0];
			y.q   = {x.q[62:0], 1'b0};
		end
		return y;
	endfunction

	// One root bit of the 64-bit square root.
	function automatic fsq_t fsq_step(fsq_t x);
		logic [34:0] rs;
		logic [34:0] trial;
		logic        ge;
		fsq_t y;
		rs    = {x.rem, x.xs[63:62]};
		trial = {1'b0, x.root, 2'b01};
		ge    = (rs >= trial);
		y.rem  = ge ? 33'(rs - trial) : 33'(rs);
		y.root = {x.root[30:0], ge};
		y.xs   = {x.xs[61:0], 2'b00};
		return y;
	endfunction

	// One quotient bit of the blend division.
	function automatic fbl_t fbl_step(fbl_t x, logic [16:0] den);
		logic [17:0] rs;
		logic        ge;
		fbl_t y;
		rs = {x.rem, x.nq[16]};
		ge = (rs >= {1'b0, den});
		y = x;
		y.rem = ge ? 17'(rs - {1'b0, den}) : 17'(rs);
		y.nq  = {x.nq[15:0], ge};
		return y;
	endfunction

	// One root bit of the 112-bit square root.
	function automatic rsq_t rsq_step(rsq_t x);
		logic [58:0] rs;
		logic [58:0] trial;
		logic        ge;
		rsq_t y;
		rs    = {x.rem, x.xs[111:110]};
		trial = {1'b0, x.root, 2'b01};
		ge    = (rs >= trial);
		y.rem  = ge ? 57'(rs - trial) : 57'(rs);
		y.root = {x.root[54:0], ge};
		y.xs   = {x.xs[109:0], 2'b00};
		y.t    = x.t;
		return y;
	endfunction

	// One quotient bit of the linear loss division.
	function automatic rdiv_t rdiv_step(rdiv_t x, logic [17:0] dv);
		logic [18:0] rs;
		logic        ge;
		rdiv_t y;
		rs = {x.rem, x.nq[56]};
		ge = (rs >= {1'b0, dv});
		y.rem = ge ? 18'(rs - {1'b0, dv}) : 18'(rs);
		y.nq  = {x.nq[55:0], ge};
		return y;
	endfunction

	// One quotient bit of the standard loss division.
	function automatic sdiv_t sdiv_step(sdiv_t x, logic [16:0] dv);
		logic [17:0] rs;
		logic        ge;
		sdiv_t y;
		rs = {x.rem, x.nq[47]};
		ge = (rs >= {1'b0, dv});
		y.rem = ge ? 17'(rs - {1'b0, dv}) : 17'(rs);
		y.nq  = {x.nq[46:0], ge};
		return y;
	endfunction

endpackage

`default_nettype wire

>>> rtl/truncated_ls_graduated_weight.sv
// Truncated least-squares robust weight and loss with graduated non-convexity, pipelined.
`default_nettype none

// Channel  | Handshake                | Payload
// ---------+--------------------------+-------------------------------------
// input    | in_valid / in_ready      | residual (signed Q16.16)
// output   | out_valid / out_ready    | weight_out, loss_out, loss_valid
// config   | cfg_we                   | cfg_addr, cfg_wdata
//
// One beat per cycle is accepted while the skid register is empty. The pipeline depth
// is set by the 64-step fractional divider and the 56-step square root followed by the
// 57-step loss divider, one bit per stage.
// Reset clears the valid chain and the output and skid valid flags, and sets the configuration to its defaults.
// The whole pipeline holds only while the skid register is full; a waiting result
// does not block input until both output registers are occupied.

module truncated_ls_graduated_weight
	import tlsgw_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] residual,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [16:0]             weight_out,
	output logic [47:0]             loss_out,
	output logic                    loss_valid,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_addr,
	input  wire logic [31:0]        cfg_wdata
);

	// Configuration and derived constants.
	logic [31:0] shape_q;
	logic [16:0] mu_q;
	logic [1:0]  scheme_q;
	logic [48:0] p_q;
	logic [16:0] den_c;
	logic [31:0] half_c2;

	// Pipeline control.
	logic               adv;
	logic [N_VALID:1]   v_q;

	// Front stages.
	logic [31:0] abs_c;
	logic [31:0] a_s1;
	logic [62:0] d2_s2;
	logic [62:0] d2_s3;
	logic [79:0] dm_s3;
	logic [62:0] d2_s4;
	logic [56:0] dmm_lo_s4;
	logic [56:0] dmm_hi_s4;
	logic [96:0] dmm_c;
	logic [49:0] t_s4;
	side_t       side4_s4;
	side_t       side4_c;
	logic [62:0] d2_s5;
	logic [49:0] t_s5;
	side_t       side5_c;

	// Units and the side chain.
	side_t  side_s [0:N_SIDE];
	fdiv_t  fdiv_seed;
	fdiv_t  fdiv_s [1:NF_DIV];
	fsq_t   fsq_seed;
	fsq_t   fsq_s [1:NF_SQ];
	fbl_t   fbl_seed;
	fbl_t   fbl_s [0:NB_DIV];
	logic [16:0] wbl_c;
	logic [16:0] wb_s [1:2];
	rmul_t  rmul_s1;
	rsq_t   rsq_s [0:NR_SQ];
	rdiv_t  rdiv_seed;
	rdiv_t  rdiv_s [0:NR_DIV];
	sdiv_t  sdiv_seed;
	sdiv_t  sdiv_s [1:NS_DIV];

	// Final selection and output registers.
	logic [16:0] fin_w;
	logic [47:0] fin_l;
	logic        fin_lv;
	logic        out_valid_q;
	logic        skid_v_q;
	logic [16:0] weight_q;
	logic [47:0] loss_q;
	logic        loss_valid_q;
	logic [16:0] skid_w_q;
	logic [47:0] skid_l_q;
	logic        skid_lv_q;
	logic        push;
	logic        take_out;

	// Configuration writes; mu is stored already clamped to 1.0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q  <= SHAPE_RESET;
			mu_q     <= MU_ONE;
			scheme_q <= SCH_STD;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_SHAPE:  shape_q  <= cfg_wdata;
				CFG_MU:     mu_q     <= (cfg_wdata[16:0] > MU_ONE) ? MU_ONE : cfg_wdata[16:0];
				CFG_SCHEME: scheme_q <= cfg_wdata[1:0];
				default:    ;
			endcase
		end
	end

	// Threshold scaled by mu, kept in step with the configuration.
	always_ff @(posedge clk) begin
		p_q <= 49'(shape_q) * 49'(mu_q);
	end

	assign den_c   = 17'(MU_ONE - mu_q);
	assign half_c2 = 32'((33'(shape_q) + 33'd1) >> 1);

	// The pipeline moves unless the skid register is occupied.
	assign adv      = !skid_v_q;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[N_VALID-1:1], in_valid};
		end
	end

	// Stage 1: magnitude of the residual.
	assign abs_c = residual[31] ? 32'(~$unsigned(residual) + 32'd1) : $unsigned(residual);

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= abs_c;
		end
	end

	// Stages 2 and 3: squared residual and its product with mu.
	always_ff @(posedge clk) begin
		if (adv) begin
			d2_s2 <= 63'(64'(a_s1) * 64'(a_s1));
			d2_s3 <= d2_s2;
			dm_s3 <= 80'(d2_s2) * 80'(mu_q);
		end
	end

	// Stage 4: threshold compares, half of d2, linear loss offset and d2*mu^2 in two halves.
	always_comb begin
		side4_c.beyond   = 64'(d2_s3) > 64'({shape_q, 16'b0});
		side4_c.le_p     = 64'(d2_s3) <= 64'(p_q);
		side4_c.lin_zero = dm_s3 >= 80'({shape_q, 32'b0});
		side4_c.std_one  = dm_s3 <= 80'({shape_q, 32'b0});
		side4_c.sup_zero = 1'b0;
		side4_c.half_d2  = 46'((64'(d2_s3) + 64'd65536) >> 17);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side4_s4  <= side4_c;
			d2_s4     <= d2_s3;
			dmm_lo_s4 <= 57'(dm_s3[39:0]) * 57'(mu_q);
			dmm_hi_s4 <= 57'(dm_s3[79:40]) * 57'(mu_q);
			t_s4      <= 50'(p_q) + 50'(dm_s3[63:16]);
		end
	end

	// Stage 5: superlinear cutoff compare at c2/mu^2.
	assign dmm_c = 97'(dmm_lo_s4) + (97'(dmm_hi_s4) << 40);

	always_comb begin
		side5_c          = side4_s4;
		side5_c.sup_zero = (mu_q != '0) && (dmm_c >= 97'({shape_q, 48'b0}));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side5_c;
			d2_s5     <= d2_s4;
			t_s5      <= t_s4;
		end
	end

	// Side flags travel alongside the long units.
	for (genvar k = 1; k <= N_SIDE; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// Fractional quotient p/d2 (linear) or c2/d2 (superlinear), one bit per stage.
	always_comb begin
		fdiv_seed.rem = (scheme_q == SCH_LIN) ? 63'(p_q) : 63'({shape_q, 16'b0});
		fdiv_seed.q   = '0;
		fdiv_seed.den = d2_s5;
	end

	for (genvar k = 1; k <= NF_DIV; k++) begin : g_fdiv
		if (k == 1) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					fdiv_s[k] <= fdiv_step(fdiv_seed);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv) begin
					fdiv_s[k] <= fdiv_step(fdiv_s[k-1]);
				end
			end
		end
	end

	// Square root of the quotient gives s in Q.32.
	always_comb begin
		fsq_seed.rem  = '0;
		fsq_seed.root = '0;
		fsq_seed.xs   = fdiv_s[NF_DIV].q;
	end

	for (genvar k = 1; k <= NF_SQ; k++) begin : g_fsq
		if (k == 1) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					fsq_s[k] <= fsq_step(fsq_seed);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv) begin
					fsq_s[k] <= fsq_step(fsq_s[k-1]);
				end
			end
		end
	end

	// Blend numerator s - mu + (1-mu)/2, with the zero and saturation cases found up front.
	always_comb begin
		logic [33:0] numer;
		numer = 34'(fsq_s[NF_SQ].root) - 34'({mu_q, 16'b0}) + 34'(den_c >> 1);
		fbl_seed.zero = {1'b0, fsq_s[NF_SQ].root} <= {mu_q, 16'b0};
		fbl_seed.ovf  = numer >= {den_c, 17'b0};
		fbl_seed.rem  = numer[33:17];
		fbl_seed.nq   = numer[16:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fbl_s[0] <= fbl_seed;
		end
	end

	for (genvar k = 1; k <= NB_DIV; k++) begin : g_fbl
		always_ff @(posedge clk) begin
			if (adv) begin
				fbl_s[k] <= fbl_step(fbl_s[k-1], den_c);
			end
		end
	end

	// Blended weight, clamped to 1.0, then delayed to line up with the loss path.
	always_comb begin
		if (fbl_s[NB_DIV].zero) begin
			wbl_c = '0;
		end else if (fbl_s[NB_DIV].ovf || (fbl_s[NB_DIV].nq > MU_ONE)) begin
			wbl_c = MU_ONE;
		end else begin
			wbl_c = fbl_s[NB_DIV].nq;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wb_s[1] <= wbl_c;
			wb_s[2] <= wb_s[1];
		end
	end

	// Linear loss: partial products of p*d2, then their sum.
	always_ff @(posedge clk) begin
		if (adv) begin
			rmul_s1.pp0 <= 64'(d2_s5[31:0]) * 64'(p_q[31:0]);
			rmul_s1.pp1 <= 49'(d2_s5[31:0]) * 49'(p_q[48:32]);
			rmul_s1.pp2 <= 63'(d2_s5[62:32]) * 63'(p_q[31:0]);
			rmul_s1.pp3 <= 48'(d2_s5[62:32]) * 48'(p_q[48:32]);
			rmul_s1.t   <= t_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsq_s[0].rem  <= '0;
			rsq_s[0].root <= '0;
			rsq_s[0].xs   <= 112'(rmul_s1.pp0) + (112'(rmul_s1.pp1) << 32)
				+ (112'(rmul_s1.pp2) << 32) + (112'(rmul_s1.pp3) << 64);
			rsq_s[0].t    <= rmul_s1.t;
		end
	end

	for (genvar k = 1; k <= NR_SQ; k++) begin : g_rsq
		always_ff @(posedge clk) begin
			if (adv) begin
				rsq_s[k] <= rsq_step(rsq_s[k-1]);
			end
		end
	end

	// Numerator max(2R - T, 0) + (1-mu) for the loss division.
	always_comb begin
		logic [56:0] two_r;
		logic [56:0] n2;
		two_r = {rsq_s[NR_SQ].root, 1'b0};
		n2    = (two_r > 57'(rsq_s[NR_SQ].t)) ? (two_r - 57'(rsq_s[NR_SQ].t)) : '0;
		rdiv_seed.rem = '0;
		rdiv_seed.nq  = n2 + 57'(den_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rdiv_s[0] <= rdiv_seed;
		end
	end

	for (genvar k = 1; k <= NR_DIV; k++) begin : g_rdiv
		always_ff @(posedge clk) begin
			if (adv) begin
				rdiv_s[k] <= rdiv_step(rdiv_s[k-1], {den_c, 1'b0});
			end
		end
	end

	// Standard truncated loss depends on configuration only; its divider runs freely.
	always_comb begin
		sdiv_seed.rem = '0;
		sdiv_seed.nq  = 48'({shape_q, 15'b0}) + 48'(mu_q >> 1);
	end

	for (genvar k = 1; k <= NS_DIV; k++) begin : g_sdiv
		if (k == 1) begin : g_first
			always_ff @(posedge clk) begin
				sdiv_s[k] <= sdiv_step(sdiv_seed, mu_q);
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				sdiv_s[k] <= sdiv_step(sdiv_s[k-1], mu_q);
			end
		end
	end

	// Final selection by scheme and endpoint cases.
	always_comb begin
		side_t       sd;
		logic [47:0] hd;
		logic [47:0] hc;
		logic [47:0] ll;
		logic        mz;
		logic        mone;
		sd   = side_s[N_SIDE];
		hd   = 48'(sd.half_d2);
		hc   = 48'(half_c2);
		ll   = (rdiv_s[NR_DIV].nq[56:48] != '0) ? LOSS_MAX : rdiv_s[NR_DIV].nq[47:0];
		mz   = (mu_q == '0);
		mone = (mu_q == MU_ONE);
		fin_w  = '0;
		fin_l  = '0;
		fin_lv = 1'b1;
		case (scheme_q)
			SCH_LIN: begin
				if (mz) begin
					fin_w = MU_ONE;
					fin_l = hd;
				end else if (mone) begin
					fin_w = sd.beyond ? '0 : MU_ONE;
					fin_l = sd.beyond ? hc : hd;
				end else if (sd.le_p) begin
					fin_w = MU_ONE;
					fin_l = hd;
				end else if (sd.lin_zero) begin
					fin_w = '0;
					fin_l = hc;
				end else begin
					fin_w = wb_s[2];
					fin_l = ll;
				end
			end
			SCH_SUP: begin
				fin_lv = 1'b0;
				if (mone) begin
					fin_w = sd.beyond ? '0 : MU_ONE;
				end else if (!sd.beyond) begin
					fin_w = MU_ONE;
				end else if (sd.sup_zero) begin
					fin_w = '0;
				end else begin
					fin_w = wb_s[2];
				end
			end
			default: begin
				if (mz || sd.std_one) begin
					fin_w = MU_ONE;
					fin_l = hd;
				end else begin
					fin_w = '0;
					fin_l = sdiv_s[NS_DIV].nq;
				end
			end
		endcase
	end

	// Output register with a skid register behind it.
	assign push     = v_q[N_VALID] && adv;
	assign take_out = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_v_q    <= 1'b0;
		end else if (take_out || !out_valid_q) begin
			if (skid_v_q) begin
				out_valid_q <= 1'b1;
				skid_v_q    <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_out || !out_valid_q) begin
			if (skid_v_q) begin
				weight_q     <= skid_w_q;
				loss_q       <= skid_l_q;
				loss_valid_q <= skid_lv_q;
			end else if (push) begin
				weight_q     <= fin_w;
				loss_q       <= fin_l;
				loss_valid_q <= fin_lv;
			end
		end else if (push) begin
			skid_w_q  <= fin_w;
			skid_l_q  <= fin_l;
			skid_lv_q <= fin_lv;
		end
	end

	assign out_valid  = out_valid_q;
	assign weight_out = weight_q;
	assign loss_out   = loss_q;
	assign loss_valid = loss_valid_q;

	// The skid register only fills behind an occupied output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_valid_q)
		else $error("skid register holds a beat while the output register is empty");

	// The skid register fills only when the output beat was refused.
	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid register filled without an output stall");

	// The weight never exceeds 1.0.
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (weight_q <= MU_ONE))
		else $error("weight above 1.0");

	// A beat without a defined loss carries a zero loss.
	a_loss_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !loss_valid_q) |-> (loss_q == '0))
		else $error("loss not cleared for a beat without a loss");

endmodule

`default_nettype wire
